[rtl/core/cmr_pkg.sv]
// cmr_pkg: shared types, codes and helpers of the cartridge mapper
// used by every module under rtl/core
package cmr_pkg;

	localparam int RAM_ENTRIES = 32;
	localparam int RAM_AW      = $clog2(RAM_ENTRIES);

	// request kinds on the input tuser
	localparam logic [1:0] REQ_READ  = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_TICK  = 2'd2;

	// register port decode
	localparam logic [15:0] PORT_MASK = 16'he001;
	localparam logic [15:0] PORT_EVEN = 16'ha000;
	localparam logic [15:0] PORT_ODD  = 16'ha001;

	// register indexes
	localparam logic [3:0] REG_BANK_LO = 4'h0;
	localparam logic [3:0] REG_BANK_HI = 4'h1;
	localparam logic [3:0] REG_IN_LO   = 4'h4;
	localparam logic [3:0] REG_IN_HI   = 4'h5;
	localparam logic [3:0] REG_MODE    = 4'h6;
	localparam logic [3:0] REG_CMD     = 4'h7;
	localparam logic [3:0] REG_STATUS  = 4'ha;
	localparam logic [3:0] REG_OUT_LO  = 4'hc;
	localparam logic [3:0] REG_OUT_HI  = 4'hd;

	// access modes
	localparam logic [2:0] MODE_RAM_WR = 3'd0;
	localparam logic [2:0] MODE_RAM_RD = 3'd1;
	localparam logic [2:0] MODE_CLOCK  = 3'd2;
	localparam logic [2:0] MODE_SETUP  = 3'd4;

	// command targets by ram index
	localparam logic [4:0] IDX_DATE      = 5'd0;
	localparam logic [4:0] IDX_CTRL      = 5'd2;
	localparam logic [4:0] IDX_MINUTE    = 5'd4;
	localparam logic [4:0] IDX_HOUR      = 5'd5;
	localparam logic [4:0] IDX_DIGIT_CLR = 5'd6;

	// setup subcommands in the low input nibble
	localparam logic [3:0] SUB_DAY_LO  = 4'h7;
	localparam logic [3:0] SUB_DAY_HI  = 4'h8;
	localparam logic [3:0] SUB_MON_LO  = 4'h9;
	localparam logic [3:0] SUB_MON_HI  = 4'ha;
	localparam logic [3:0] SUB_YEAR_LO = 4'hb;
	localparam logic [3:0] SUB_YEAR_HI = 4'hc;
	localparam logic [3:0] SUB_HMODE   = 4'ha;
	localparam logic [3:0] SUB_LEAP    = 4'hb;

	localparam logic [7:0] SECS_PER_MIN  = 8'd60;
	localparam logic [7:0] HOURS_12      = 8'd12;
	localparam logic [7:0] HOURS_24      = 8'd24;
	localparam logic [7:0] MONTHS        = 8'd12;
	localparam logic [7:0] YEARS_PER_CEN = 8'd100;

	typedef struct packed {
		logic       tick;
		logic       set_minute;
		logic       set_hour;
		logic       digit_clr;
		logic       digit_adv;
		logic       set_day;
		logic       set_month;
		logic       set_year;
		logic       nib_high;
		logic       set_hmode;
		logic       set_leap;
		logic [7:0] data;
	} rtc_cmd_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic        rom_access;
		logic [18:0] rom_address;
	} res_t;

	// quotient by ten, exact for all byte values
	function automatic logic [4:0] div10(input logic [7:0] v);
		logic [15:0] p;
		p = {8'd0, v} * 16'd205;
		return p[15:11];
	endfunction

	function automatic logic [3:0] mod10(input logic [7:0] v);
		logic [4:0] q;
		logic [7:0] qt;
		q  = div10(v);
		qt = {3'd0, q} * 8'd10;
		return 4'(v - qt);
	endfunction

	function automatic logic [7:0] bin_to_bcd(input logic [7:0] v);
		logic [4:0] q;
		q = div10(v);
		return {q[3:0], mod10(v)};
	endfunction

	function automatic logic [7:0] bcd_to_bin(input logic [7:0] v);
		logic [7:0] t;
		t = {4'd0, v[7:4]} * 8'd10;
		return 8'(t + {4'd0, v[3:0]});
	endfunction

	function automatic logic [7:0] set_bcd_nibble(input logic [7:0] v, input logic high,
			input logic [3:0] nib);
		logic [7:0] b;
		b = bin_to_bcd(v);
		if (high) begin
			b = {nib, b[3:0]};
		end else begin
			b = {b[7:4], nib};
		end
		return bcd_to_bin(b);
	endfunction

	// days in month for a wrapped month byte, february without leap
	function automatic logic [4:0] month_days(input logic [7:0] month);
		logic [7:0]  m1;
		logic [13:0] p;
		logic [4:0]  q;
		logic [7:0]  qt;
		logic [3:0]  idx;
		logic [4:0]  d;
		m1  = 8'(month - 8'd1);
		p   = {8'd0, m1[7:2]} * 14'd171;
		q   = p[13:9];
		qt  = {3'd0, q} * 8'd12;
		idx = 4'(m1 - qt);
		case (idx)
			4'd1: d = 5'd28;
			4'd3, 4'd5, 4'd8, 4'd10: d = 5'd30;
			default: d = 5'd31;
		endcase
		return d;
	endfunction

endpackage

[rtl/core/cmr_save_ram.sv]
// cmr_save_ram: 32-byte save memory, one write and one registered read per cycle
// entries read as zero until written; uses cmr_pkg
module cmr_save_ram (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic [cmr_pkg::RAM_AW-1:0] wr_addr,
	input  logic [7:0]               wr_data,
	input  logic                     rd_en,
	input  logic [cmr_pkg::RAM_AW-1:0] rd_addr,
	output logic [7:0]               rd_data
);
	import cmr_pkg::*;

	logic [7:0]             mem [RAM_ENTRIES];
	logic [RAM_ENTRIES-1:0] vld_q;
	logic [7:0]             rd_word_q;
	logic                   rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_word_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_word_q : 8'd0;

	a_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && rd_en))
		else $error("save ram written and read by one command");

endmodule

[rtl/core/cmr_rtc.sv]
// cmr_rtc: calendar clock registers, tick advance, setters and digit readout
// uses cmr_pkg
module cmr_rtc (
	input  logic              clk,
	input  logic              arst_n,
	input  cmr_pkg::rtc_cmd_t cmd,
	output logic [3:0]        digit
);
	import cmr_pkg::*;

	logic [7:0] year_q, month_q, day_q, hour_q, minute_q, second_q;
	logic       pm_q, hmode24_q;
	logic [1:0] leap_q;
	logic [3:0] digit_idx_q;

	logic [7:0] year_d, month_d, day_d, hour_d, minute_d, second_d;
	logic       pm_d;
	logic [1:0] leap_d;
	logic [7:0] sec1, min1, hour1, day1, mon1, yr1;
	logic [7:0] lim;
	logic [7:0] hour_set;
	logic [7:0] dsrc;
	logic       dhigh;

	// one-second advance
	always_comb begin
		year_d   = year_q;
		month_d  = month_q;
		day_d    = day_q;
		hour_d   = hour_q;
		minute_d = minute_q;
		second_d = second_q;
		pm_d     = pm_q;
		leap_d   = leap_q;
		sec1     = 8'(second_q + 8'd1);
		min1     = 8'(minute_q + 8'd1);
		hour1    = 8'(hour_q + 8'd1);
		day1     = 8'(day_q + 8'd1);
		mon1     = 8'(month_q + 8'd1);
		yr1      = 8'(year_q + 8'd1);
		lim      = {3'd0, month_days(month_q)};
		if (lim == 8'd28 && leap_q == 2'd0) begin
			lim = 8'd29;
		end
		if (sec1 < SECS_PER_MIN) begin
			second_d = sec1;
		end else begin
			second_d = 8'd0;
			if (min1 < SECS_PER_MIN) begin
				minute_d = min1;
			end else begin
				minute_d = 8'd0;
				hour_d   = hour1;
				if (!hmode24_q && hour1 >= HOURS_12) begin
					hour_d = 8'd0;
					pm_d   = ~pm_q;
				end
				if (hmode24_q && hour1 >= HOURS_24) begin
					hour_d = 8'd0;
					pm_d   = 1'b0;
				end
				if (hour_d == 8'd0 && !(!hmode24_q && pm_d)) begin
					if (day1 <= lim) begin
						day_d = day1;
					end else begin
						day_d = 8'd1;
						if (mon1 <= MONTHS) begin
							month_d = mon1;
						end else begin
							month_d = 8'd1;
							leap_d  = 2'(leap_q + 2'd1);
							year_d  = (yr1 >= YEARS_PER_CEN) ? 8'd0 : yr1;
						end
					end
				end
			end
		end
	end

	assign hour_set = bcd_to_bin(cmd.data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_q      <= 8'd0;
			month_q     <= 8'd0;
			day_q       <= 8'd0;
			hour_q      <= 8'd0;
			minute_q    <= 8'd0;
			second_q    <= 8'd0;
			pm_q        <= 1'b0;
			hmode24_q   <= 1'b0;
			leap_q      <= 2'd0;
			digit_idx_q <= 4'd0;
		end else begin
			if (cmd.tick) begin
				year_q   <= year_d;
				month_q  <= month_d;
				day_q    <= day_d;
				hour_q   <= hour_d;
				minute_q <= minute_d;
				second_q <= second_d;
				pm_q     <= pm_d;
				leap_q   <= leap_d;
			end
			if (cmd.set_minute) begin
				minute_q <= bcd_to_bin(cmd.data);
			end
			if (cmd.set_hour) begin
				hour_q <= hour_set;
				pm_q   <= hour_set >= HOURS_12;
			end
			if (cmd.set_day) begin
				day_q <= set_bcd_nibble(day_q, cmd.nib_high, cmd.data[7:4]);
			end
			if (cmd.set_month) begin
				month_q <= set_bcd_nibble(month_q, cmd.nib_high, cmd.data[7:4]);
			end
			if (cmd.set_year) begin
				year_q <= set_bcd_nibble(year_q, cmd.nib_high, cmd.data[7:4]);
			end
			if (cmd.set_hmode) begin
				hmode24_q <= cmd.data[4];
				second_q  <= 8'd0;
			end
			if (cmd.set_leap) begin
				leap_q <= cmd.data[5:4];
			end
			if (cmd.digit_clr) begin
				digit_idx_q <= 4'd0;
			end else if (cmd.digit_adv) begin
				digit_idx_q <= 4'(digit_idx_q + 4'd1);
			end
		end
	end

	// digit order: minute, hour (ones first), day, month (tens first)
	always_comb begin
		case (digit_idx_q[2:1])
			2'd0:    dsrc = minute_q;
			2'd1:    dsrc = hour_q;
			2'd2:    dsrc = day_q;
			default: dsrc = month_q;
		endcase
		dhigh = digit_idx_q[2] ? ~digit_idx_q[0] : digit_idx_q[0];
	end

	logic [4:0] dq;
	assign dq    = div10(dsrc);
	assign digit = digit_idx_q[3] ? 4'd0 : (dhigh ? dq[3:0] : mod10(dsrc));

	a_sec_range: assert property (@(posedge clk) disable iff (!arst_n)
		second_q < SECS_PER_MIN)
		else $error("seconds counter out of range");

endmodule

[rtl/core/cmr_out_buf.sv]
// cmr_out_buf: two-entry result buffer between the mapper and the output stream
// uses cmr_pkg
module cmr_out_buf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  cmr_pkg::res_t in_word,
	output logic          in_ready,
	output logic          out_valid,
	output cmr_pkg::res_t out_word,
	input  logic          out_ready
);
	import cmr_pkg::*;

	res_t head_q, skid_q;
	logic head_vld_q, skid_vld_q;
	logic pop;

	assign in_ready  = !skid_vld_q;
	assign out_valid = head_vld_q;
	assign out_word  = head_q;
	assign pop       = head_vld_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (!head_vld_q || pop) begin
				if (skid_vld_q) begin
					head_vld_q <= 1'b1;
					skid_vld_q <= 1'b0;
				end else begin
					head_vld_q <= in_valid;
				end
			end else if (in_valid) begin
				skid_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!head_vld_q || pop) begin
			head_q <= skid_vld_q ? skid_q : in_word;
		end else if (in_valid) begin
			skid_q <= in_word;
		end
	end

	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> head_vld_q)
		else $error("skid word held with empty head");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid |-> in_ready)
		else $error("result pushed into full buffer");

endmodule

[rtl/core/cartridge_mapper_with_rtc.sv]
// cartridge_mapper_with_rtc: top level, bus decode and register port of the mapper
// instantiates cmr_save_ram, cmr_rtc, cmr_out_buf; uses cmr_pkg
//
// One word is taken every clock while the buffer has room: reads, writes and ticks all
// run at one word per cycle, and a read result is registered in the buffer head. A
// two-word result buffer lets input continue while the output stalls; the input stalls
// only once both buffer entries hold untaken results. Save-memory loads take effect in
// the cycle after the command through the registered memory read; a read of the output
// nibbles in that cycle is served from the forwarded memory data.
module cartridge_mapper_with_rtc (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // bus_address[15:0], bus_data[23:16]
	input  logic [1:0]  s_axis_tuser,  // req_type[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // read_data[7:0], rom_address[26:8], zero fill
	output logic        m_axis_tuser   // rom_access
);
	import cmr_pkg::*;

	logic       ready_q;
	logic [3:0] reg_sel_q;
	logic [2:0] mode_q;
	logic [4:0] ram_idx_q;
	logic [7:0] in_byte_q;
	logic [7:0] out_byte_q;
	logic [4:0] bank_q;
	logic       load_pend_q;

	logic        accept, is_read, is_write, port_even, port_odd;
	logic [15:0] addr;
	logic [7:0]  val;
	logic [4:0]  ram_idx_cmd;
	logic        cmd_go;
	logic [7:0]  ob_eff;
	logic [7:0]  ram_rd_data;
	logic [3:0]  digit;
	logic        digit_rd;
	logic        buf_ready;
	res_t        res, out_word;
	rtc_cmd_t    rcmd;

	assign addr          = s_axis_tdata[15:0];
	assign val           = s_axis_tdata[23:16];
	assign s_axis_tready = buf_ready;
	assign accept        = s_axis_tvalid && buf_ready;
	assign is_read       = accept && s_axis_tuser == REQ_READ;
	assign is_write      = accept && s_axis_tuser == REQ_WRITE;
	assign port_even     = (addr & PORT_MASK) == PORT_EVEN;
	assign port_odd      = (addr & PORT_MASK) == PORT_ODD;
	assign ram_idx_cmd   = {ram_idx_q[4], val[3:0]};
	assign cmd_go        = is_write && port_even && reg_sel_q == REG_CMD;
	assign ob_eff        = load_pend_q ? ram_rd_data : out_byte_q;

	// read result
	always_comb begin
		res      = '0;
		digit_rd = 1'b0;
		if (!addr[15]) begin
			res.rom_access  = 1'b1;
			res.rom_address = {(addr[14] ? bank_q : 5'd0), addr[13:0]};
		end else begin
			res.read_data = 8'hff;
			if (port_even) begin
				if (reg_sel_q == REG_STATUS) begin
					res.read_data = {7'b1111000, ready_q};
				end else if (mode_q <= MODE_RAM_RD && reg_sel_q == REG_OUT_LO) begin
					res.read_data = {4'hf, ob_eff[3:0]};
				end else if (mode_q <= MODE_RAM_RD && reg_sel_q == REG_OUT_HI) begin
					res.read_data = {4'hf, ob_eff[7:4]};
				end else if ((mode_q == MODE_CLOCK || mode_q == MODE_SETUP)
						&& (reg_sel_q == REG_OUT_LO || reg_sel_q == REG_OUT_HI)) begin
					res.read_data = {4'hf, digit};
					digit_rd      = 1'b1;
				end
			end
		end
	end

	// clock commands
	always_comb begin
		rcmd            = '0;
		rcmd.data       = in_byte_q;
		rcmd.tick       = accept && s_axis_tuser == REQ_TICK;
		rcmd.digit_adv  = is_read && digit_rd;
		rcmd.nib_high   = in_byte_q[3:0] == SUB_DAY_HI || in_byte_q[3:0] == SUB_MON_HI
			|| in_byte_q[3:0] == SUB_YEAR_HI;
		if (cmd_go && mode_q == MODE_CLOCK) begin
			rcmd.set_minute = ram_idx_cmd == IDX_MINUTE;
			rcmd.set_hour   = ram_idx_cmd == IDX_HOUR;
			rcmd.digit_clr  = ram_idx_cmd == IDX_DIGIT_CLR;
		end
		if (cmd_go && mode_q == MODE_SETUP && ram_idx_cmd == IDX_DATE) begin
			rcmd.set_day   = in_byte_q[3:0] == SUB_DAY_LO || in_byte_q[3:0] == SUB_DAY_HI;
			rcmd.set_month = in_byte_q[3:0] == SUB_MON_LO || in_byte_q[3:0] == SUB_MON_HI;
			rcmd.set_year  = in_byte_q[3:0] == SUB_YEAR_LO || in_byte_q[3:0] == SUB_YEAR_HI;
		end
		if (cmd_go && mode_q == MODE_SETUP && ram_idx_cmd == IDX_CTRL) begin
			rcmd.set_hmode = in_byte_q[3:0] == SUB_HMODE;
			rcmd.set_leap  = in_byte_q[3:0] == SUB_LEAP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q     <= 1'b0;
			reg_sel_q   <= 4'd0;
			mode_q      <= 3'd0;
			ram_idx_q   <= 5'd0;
			in_byte_q   <= 8'd0;
			out_byte_q  <= 8'd0;
			bank_q      <= 5'd0;
			load_pend_q <= 1'b0;
		end else begin
			load_pend_q <= cmd_go && mode_q == MODE_RAM_RD;
			if (load_pend_q) begin
				out_byte_q <= ram_rd_data;
			end
			if (is_write && port_odd) begin
				reg_sel_q <= val[3:0];
				if (val[3:0] == REG_STATUS) begin
					ready_q <= 1'b1;
				end
			end
			if (is_write && port_even) begin
				case (reg_sel_q)
					REG_BANK_LO: bank_q    <= {bank_q[4], val[3:0]};
					REG_BANK_HI: bank_q    <= {val[0], bank_q[3:0]};
					REG_IN_LO:   in_byte_q <= {in_byte_q[7:4], val[3:0]};
					REG_IN_HI:   in_byte_q <= {val[3:0], in_byte_q[3:0]};
					REG_MODE: begin
						ram_idx_q <= {val[0], ram_idx_q[3:0]};
						mode_q    <= val[3:1];
					end
					REG_CMD:     ram_idx_q <= ram_idx_cmd;
					default: begin
					end
				endcase
			end
		end
	end

	cmr_save_ram u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_go && mode_q == MODE_RAM_WR),
		.wr_addr (ram_idx_cmd),
		.wr_data (in_byte_q),
		.rd_en   (cmd_go && mode_q == MODE_RAM_RD),
		.rd_addr (ram_idx_cmd),
		.rd_data (ram_rd_data)
	);

	cmr_rtc u_rtc (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (rcmd),
		.digit  (digit)
	);

	cmr_out_buf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (is_read),
		.in_word   (res),
		.in_ready  (buf_ready),
		.out_valid (m_axis_tvalid),
		.out_word  (out_word),
		.out_ready (m_axis_tready)
	);

	assign m_axis_tdata = {5'd0, out_word.rom_address, out_word.read_data};
	assign m_axis_tuser = out_word.rom_access;

	a_load_follows_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		load_pend_q |-> $past(accept && s_axis_tuser == REQ_WRITE))
		else $error("save ram load without a command write");

endmodule
